@@ rtl/cphm_pkg.sv @@
package cphm_pkg;

    localparam int NUM_PEERS = 6;
    localparam int SLOT_W    = 3;

    localparam logic [SLOT_W-1:0] SLOT_BATTERY    = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_MOTOR_LO   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_MOTOR_HI   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_SUPERVISOR = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_LAST       = 3'(NUM_PEERS - 1);

    localparam logic [7:0]  ID_MOTOR_LO   = 8'd1;
    localparam logic [7:0]  ID_MOTOR_HI   = 8'd4;
    localparam logic [7:0]  ID_SUPERVISOR = 8'd255;
    localparam logic [31:0] WINDOW_MS     = 32'd1000;
    localparam logic [7:0]  FAIL_MAX      = 8'd255;

    localparam logic [2:0] FN_TX       = 3'd0;
    localparam logic [2:0] FN_TX_OK    = 3'd1;
    localparam logic [2:0] FN_RX       = 3'd2;
    localparam logic [2:0] FN_CHECK    = 3'd3;
    localparam logic [2:0] FN_RST_PEER = 3'd4;
    localparam logic [2:0] FN_RST_ALL  = 3'd5;

    localparam logic [1:0] CFG_MOTOR_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_FAIL_DEGRADE  = 2'd1;
    localparam logic [1:0] CFG_MAX_ERRORS    = 2'd2;

    localparam logic [15:0] RST_MOTOR_TIMEOUT = 16'd100;
    localparam logic [7:0]  RST_FAIL_DEGRADE  = 8'd3;
    localparam logic [15:0] RST_MAX_ERRORS    = 16'd10;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic  load;
        logic  op;
        logic  sweep;
        logic  fin;
        logic  resp;
        t_slot idx;
    } t_cmd;

    typedef struct packed {
        logic is_check;
    } t_status;

    function automatic t_slot slot_of(input logic [7:0] id);
        t_slot s;
        s = SLOT_BATTERY;
        if (id >= ID_MOTOR_LO && id <= ID_MOTOR_HI) begin
            s = id[SLOT_W-1:0];
        end else if (id == ID_SUPERVISOR) begin
            s = SLOT_SUPERVISOR;
        end
        return s;
    endfunction

endpackage

@@ rtl/cphm_ctrl.sv @@
module cphm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  cphm_pkg::t_status   i_status,
    output cphm_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OP    = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]          r_state, n_state;
    cphm_pkg::t_slot     r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic                w_accept;
    logic                w_resp_fire;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_resp_fire = (r_state == S_RESP) && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_idx      = cphm_pkg::SLOT_BATTERY;
                    n_state    = i_status.is_check ? S_SWEEP : S_OP;
                end
            end
            S_OP: begin
                o_cmd.op = 1'b1;
                n_state  = S_RESP;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (r_idx == cphm_pkg::SLOT_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + cphm_pkg::t_slot'(1);
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (w_resp_fire) begin
                    o_cmd.resp  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RESP)
        else $error("result raised outside response state");
    a_check_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_status.is_check) |=> (r_state == S_SWEEP && r_idx == '0))
        else $error("health check did not start slot sweep at slot 0");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> r_idx <= cphm_pkg::SLOT_LAST)
        else $error("sweep index out of range");
    a_fin_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> ($past(r_state) == S_SWEEP &&
                              $past(r_idx) == cphm_pkg::SLOT_LAST))
        else $error("finish entered before full sweep");
`endif

endmodule

@@ rtl/cphm_dp.sv @@
module cphm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic [2:0]          i_func,
    input  logic [7:0]          i_peer_id,
    input  logic [31:0]         i_now_ms,
    input  cphm_pkg::t_cmd      i_cmd,
    output cphm_pkg::t_status   o_status,
    output logic [1:0]          o_health,
    output logic [5:0]          o_timeout_mask,
    output logic [5:0]          o_error_mask,
    output logic                o_bus_off,
    output logic [15:0]         o_msgs_per_second,
    output logic [2:0]          o_peer_flags,
    output logic [7:0]          o_peer_failures,
    output logic [31:0]         o_peer_rx_count,
    output logic [31:0]         o_peer_tx_count,
    output logic [31:0]         o_peer_timeouts,
    output logic [31:0]         o_peer_errors,
    output logic [31:0]         o_total_errors
);

    localparam int NP = cphm_pkg::NUM_PEERS;

    logic [15:0] r_motor_timeout;
    logic [7:0]  r_fail_degrade;
    logic [15:0] r_max_errors;

    logic [2:0]       r_func;
    cphm_pkg::t_slot  r_slot;
    logic [31:0]      r_now;

    logic        r_conn    [0:NP-1];
    logic        r_resp    [0:NP-1];
    logic        r_degr    [0:NP-1];
    logic [7:0]  r_fail    [0:NP-1];
    logic [31:0] r_last_rx [0:NP-1];
    logic [31:0] r_win_st  [0:NP-1];
    logic [15:0] r_win_cnt [0:NP-1];
    logic [31:0] r_rx_tot  [0:NP-1];
    logic [31:0] r_tx_tot  [0:NP-1];
    logic [31:0] r_to_tot  [0:NP-1];
    logic [31:0] r_err_tot [0:NP-1];

    logic [31:0] r_glob_err;
    logic        r_bus_ok;
    logic [15:0] r_rate_sum;

    logic [15:0] r_sum;
    logic        r_crit;
    logic [5:0]  r_tmask;
    logic [5:0]  r_emask;
    logic        r_off;

    cphm_pkg::t_slot k;
    logic [31:0] w_win_age;
    logic [31:0] w_rx_age;
    logic        w_motor;
    logic        w_tout;
    logic [7:0]  w_fail_inc;
    logic        w_degrade;
    logic        w_disc;
    logic [1:0]  w_err_add;

    assign o_status.is_check = (i_func == cphm_pkg::FN_CHECK);

    assign k          = i_cmd.idx;
    assign w_win_age  = r_now - r_win_st[k];
    assign w_rx_age   = r_now - r_last_rx[k];
    assign w_motor    = (k >= cphm_pkg::SLOT_MOTOR_LO) && (k <= cphm_pkg::SLOT_MOTOR_HI);
    assign w_tout     = w_motor && r_conn[k] && r_resp[k] &&
                        (w_rx_age > {16'd0, r_motor_timeout});
    assign w_fail_inc = (r_fail[k] < cphm_pkg::FAIL_MAX) ? r_fail[k] + 8'd1 : r_fail[k];
    assign w_degrade  = w_tout && (w_fail_inc >= r_fail_degrade);
    assign w_disc     = w_degrade && ({8'd0, w_fail_inc} >= r_max_errors);
    assign w_err_add  = {w_degrade, w_tout && !w_degrade};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_timeout <= cphm_pkg::RST_MOTOR_TIMEOUT;
            r_fail_degrade  <= cphm_pkg::RST_FAIL_DEGRADE;
            r_max_errors    <= cphm_pkg::RST_MAX_ERRORS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cphm_pkg::CFG_MOTOR_TIMEOUT: r_motor_timeout <= i_cfg_data;
                cphm_pkg::CFG_FAIL_DEGRADE:  r_fail_degrade  <= i_cfg_data[7:0];
                cphm_pkg::CFG_MAX_ERRORS:    r_max_errors    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_slot <= cphm_pkg::slot_of(i_peer_id);
            r_now  <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NP; s++) begin
                r_conn[s]    <= 1'b0;
                r_resp[s]    <= 1'b0;
                r_degr[s]    <= 1'b0;
                r_fail[s]    <= '0;
                r_last_rx[s] <= '0;
                r_win_st[s]  <= '0;
                r_win_cnt[s] <= '0;
                r_rx_tot[s]  <= '0;
                r_tx_tot[s]  <= '0;
                r_to_tot[s]  <= '0;
                r_err_tot[s] <= '0;
            end
            r_glob_err <= '0;
            r_bus_ok   <= 1'b1;
            r_rate_sum <= '0;
            r_sum      <= '0;
            r_crit     <= 1'b0;
            r_tmask    <= '0;
            r_emask    <= '0;
            r_off      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_sum   <= '0;
                r_crit  <= 1'b0;
                r_tmask <= '0;
                r_emask <= '0;
                r_off   <= 1'b0;
            end
            if (i_cmd.op) begin
                case (r_func)
                    cphm_pkg::FN_TX: begin
                        r_tx_tot[r_slot] <= r_tx_tot[r_slot] + 32'd1;
                    end
                    cphm_pkg::FN_TX_OK: begin
                        r_resp[r_slot] <= 1'b1;
                        r_fail[r_slot] <= '0;
                    end
                    cphm_pkg::FN_RX: begin
                        r_last_rx[r_slot] <= r_now;
                        r_rx_tot[r_slot]  <= r_rx_tot[r_slot] + 32'd1;
                        r_conn[r_slot]    <= 1'b1;
                        r_resp[r_slot]    <= 1'b1;
                        r_fail[r_slot]    <= '0;
                        r_win_cnt[r_slot] <= r_win_cnt[r_slot] + 16'd1;
                    end
                    cphm_pkg::FN_RST_PEER: begin
                        r_conn[r_slot]    <= 1'b0;
                        r_resp[r_slot]    <= 1'b0;
                        r_degr[r_slot]    <= 1'b0;
                        r_fail[r_slot]    <= '0;
                        r_last_rx[r_slot] <= '0;
                        r_win_st[r_slot]  <= r_now;
                        r_win_cnt[r_slot] <= '0;
                        r_rx_tot[r_slot]  <= '0;
                        r_tx_tot[r_slot]  <= '0;
                        r_to_tot[r_slot]  <= '0;
                        r_err_tot[r_slot] <= '0;
                    end
                    cphm_pkg::FN_RST_ALL: begin
                        for (int s = 0; s < NP; s++) begin
                            r_conn[s]    <= 1'b0;
                            r_resp[s]    <= 1'b0;
                            r_degr[s]    <= 1'b0;
                            r_fail[s]    <= '0;
                            r_last_rx[s] <= '0;
                            r_win_st[s]  <= r_now;
                            r_win_cnt[s] <= '0;
                            r_rx_tot[s]  <= '0;
                            r_tx_tot[s]  <= '0;
                            r_to_tot[s]  <= '0;
                            r_err_tot[s] <= '0;
                        end
                        r_glob_err <= '0;
                        r_bus_ok   <= 1'b1;
                        r_rate_sum <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.sweep) begin
                // window sum and restart, then motor timeout for the same slot
                r_sum <= r_sum + r_win_cnt[k];
                if (w_win_age >= cphm_pkg::WINDOW_MS) begin
                    r_win_st[k]  <= r_now;
                    r_win_cnt[k] <= '0;
                end
                if (w_tout) begin
                    r_to_tot[k] <= r_to_tot[k] + 32'd1;
                    r_resp[k]   <= 1'b0;
                    r_fail[k]   <= w_fail_inc;
                    r_tmask[k]  <= 1'b1;
                end
                if (w_degrade) begin
                    r_degr[k]    <= 1'b1;
                    r_err_tot[k] <= r_err_tot[k] + 32'd1;
                    r_emask[k]   <= 1'b1;
                    r_crit       <= 1'b1;
                end
                if (w_disc) begin
                    r_conn[k] <= 1'b0;
                    r_off     <= 1'b1;
                end
                r_glob_err <= r_glob_err + {30'd0, w_err_add};
            end
            if (i_cmd.fin) begin
                r_rate_sum <= r_sum;
                if (r_glob_err > {16'd0, r_max_errors}) begin
                    r_bus_ok <= 1'b0;
                    r_crit   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            o_health          <= {!r_bus_ok, r_crit};
            o_timeout_mask    <= r_tmask;
            o_error_mask      <= r_emask;
            o_bus_off         <= r_off;
            o_msgs_per_second <= r_rate_sum;
            o_peer_flags      <= {r_degr[r_slot], r_resp[r_slot], r_conn[r_slot]};
            o_peer_failures   <= r_fail[r_slot];
            o_peer_rx_count   <= r_rx_tot[r_slot];
            o_peer_tx_count   <= r_tx_tot[r_slot];
            o_peer_timeouts   <= r_to_tot[r_slot];
            o_peer_errors     <= r_err_tot[r_slot];
            o_total_errors    <= r_glob_err;
        end
    end

`ifndef NO_ASSERTIONS
    a_masks_motor_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tmask[0] == 1'b0 && r_tmask[5] == 1'b0))
        else $error("timeout flagged on a non-motor slot");
    a_emask_sub_tmask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emask & ~r_tmask) == 6'd0)
        else $error("error flagged on a slot that did not time out");
    a_off_needs_crit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off |-> r_crit)
        else $error("disconnect without critical");
`endif

endmodule

@@ rtl/can_peer_health_monitor_top.sv @@
// CAN peer health monitor: status for six peer slots (battery, four motors,
// supervisor), updated by timestamped events.
// Input channel (i_valid/o_ready) moves one event per transfer: i_func,
// i_peer_id, i_now_ms. Output channel (o_valid/i_ready) moves one result per
// event: check flags and masks, the rate sum and the addressed slot counters.
// The block works on one event at a time. Any event other than a health check
// passes through the op state to the response state; a health check sweeps
// each peer slot in turn, then runs the finish step and loads the output.
// Only once the result is loaded does the block return to idle and take the
// next event, so a new event is never taken before the last one is through.
// The result sits in an output register; a new event is accepted while it
// waits. If the receiver stalls, the following result is held back inside
// the block until the output register frees, and no event is taken meanwhile.
// Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once; the
// user must make them only while idle, as the block does not enforce this.
// Reset (synchronous, active low) clears all slots and counters, sets the bus
// healthy, and loads the default timeout, degrade and error limits.
module can_peer_health_monitor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_peer_id,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_health,
    output logic [5:0]  o_timeout_mask,
    output logic [5:0]  o_error_mask,
    output logic        o_bus_off,
    output logic [15:0] o_msgs_per_second,
    output logic [2:0]  o_peer_flags,
    output logic [7:0]  o_peer_failures,
    output logic [31:0] o_peer_rx_count,
    output logic [31:0] o_peer_tx_count,
    output logic [31:0] o_peer_timeouts,
    output logic [31:0] o_peer_errors,
    output logic [31:0] o_total_errors
);

    cphm_pkg::t_cmd    w_cmd;
    cphm_pkg::t_status w_status;

    cphm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    cphm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_peer_id         (i_peer_id),
        .i_now_ms          (i_now_ms),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_health          (o_health),
        .o_timeout_mask    (o_timeout_mask),
        .o_error_mask      (o_error_mask),
        .o_bus_off         (o_bus_off),
        .o_msgs_per_second (o_msgs_per_second),
        .o_peer_flags      (o_peer_flags),
        .o_peer_failures   (o_peer_failures),
        .o_peer_rx_count   (o_peer_rx_count),
        .o_peer_tx_count   (o_peer_tx_count),
        .o_peer_timeouts   (o_peer_timeouts),
        .o_peer_errors     (o_peer_errors),
        .o_total_errors    (o_total_errors)
    );

endmodule
